>>> hdl/ccss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccss_pkg
// shared types and constants of the command stepper sequencer
// ----------------------------------------------------------------------------
package ccss_pkg;

  localparam int NumDigits    = 5;
  localparam int PositionBits = 17;
  localparam int IdxBits      = 4;
  localparam int CfgIdxBits   = 3;
  localparam int CfgDataBits  = 10;

  localparam logic [PositionBits-1:0] MicronMax = 17'd131071;
  localparam logic [PositionBits-1:0] PosMask   = '1;

  localparam logic [7:0] ChStart = 8'h78;
  localparam logic [7:0] ChDown  = 8'h31;
  localparam logic [7:0] ChUp    = 8'h32;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [CfgIdxBits-1:0] RegXMps   = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegYMps   = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegXyHalf = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegZDown  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegZUp    = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegZCount = 3'd5;

  // one accepted item as it travels from front to back
  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } item_t;

  // one result item
  typedef struct packed {
    logic x_step;
    logic x_dir;
    logic y_step;
    logic y_dir;
    logic z_step;
    logic z_dir;
    logic ack;
    logic busy_res;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/ccss_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccss_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ccss_div
  import ccss_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [PositionBits-1:0] dividend,
  input  wire logic [CfgDataBits-1:0]  divisor,
  output logic                         done,
  output logic [PositionBits-1:0]      quotient
);

  localparam int CntBits = $clog2(PositionBits + 1);

  logic [PositionBits-1:0] quo;
  logic [CfgDataBits:0]    rem;
  logic [CfgDataBits-1:0]  dsr;
  logic [CntBits-1:0]      count;
  logic                    running;
  logic [CfgDataBits:0]    trial;
  logic [CfgDataBits:0]    shifted;

  always_comb begin
    shifted = {rem[CfgDataBits-1:0], quo[PositionBits-1]};
    trial   = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      running <= 1'b0;
      count   <= '0;
    end else if (start) begin
      if (divisor == '0) begin
        quotient <= PosMask;
        done     <= 1'b1;
      end else begin
        running <= 1'b1;
        count   <= CntBits'(PositionBits);
        quo     <= dividend;
        rem     <= '0;
        dsr     <= divisor;
      end
    end else if (running) begin
      if (trial[CfgDataBits]) begin
        rem <= shifted;
        quo <= {quo[PositionBits-2:0], 1'b0};
      end else begin
        rem <= trial;
        quo <= {quo[PositionBits-2:0], 1'b1};
      end
      count <= count - 1'b1;
      if (count == CntBits'(1)) begin
        running  <= 1'b0;
        done     <= 1'b1;
        quotient <= trial[CfgDataBits] ? {quo[PositionBits-2:0], 1'b0}
                                       : {quo[PositionBits-2:0], 1'b1};
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/ccss_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccss_front
// input side: takes items into a short queue for the back end
// ----------------------------------------------------------------------------
module ccss_front
  import ccss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic       kind,
  input  wire logic [7:0] rx_byte,
  output logic            full,
  input  wire logic       take,
  output logic            avail,
  output item_t           head
);

  item_t      q [2];
  logic [1:0] cnt;
  logic       rd, wr;
  logic       do_push;

  assign full    = cnt == 2'd2;
  assign avail   = cnt != 2'd0;
  assign head    = q[rd];
  assign do_push = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd  <= 1'b0;
      wr  <= 1'b0;
    end else begin
      if (do_push) begin
        q[wr] <= '{kind: kind, rx_byte: rx_byte};
        wr    <= ~wr;
      end
      if (take && avail) rd <= ~rd;
      cnt <= cnt + {1'b0, do_push} - {1'b0, take && avail};
    end
  end

endmodule
`default_nettype wire

>>> hdl/ccss_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccss_back
// command parser and motion sequencer, one item at a time
// ----------------------------------------------------------------------------
module ccss_back
  import ccss_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   avail,
  input  wire item_t                  head,
  output logic                        take,
  input  wire logic [CfgDataBits-1:0] x_mps,
  input  wire logic [CfgDataBits-1:0] y_mps,
  input  wire logic [7:0]             xy_half,
  input  wire logic [7:0]             z_down_half,
  input  wire logic [7:0]             z_up_half,
  input  wire logic [7:0]             z_count,
  output logic                        res_valid,
  output result_t                     res,
  input  wire logic                   res_taken
);

  localparam logic [IdxBits-1:0] LastX   = IdxBits'(NumDigits);
  localparam logic [IdxBits-1:0] YStart  = IdxBits'(NumDigits + 1);
  localparam logic [IdxBits-1:0] LastY   = IdxBits'(2 * NumDigits + 1);
  localparam logic [IdxBits-1:0] PenIdx  = IdxBits'(2 * NumDigits + 3);

  typedef enum logic [2:0] {
    PH_IDLE, PH_ZH, PH_ZL, PH_XH, PH_XL, PH_YH, PH_YL
  } phase_t;

  typedef enum logic [1:0] {S_RUN, S_DIVX, S_DIVY, S_OUT} seq_t;

  seq_t                    seq;
  phase_t                  phase;
  logic [IdxBits-1:0]      byte_index;
  logic [PositionBits-1:0] x_tm, y_tm, x_pos, y_pos, steps_left, x_ts, y_ts;
  logic                    frozen, pen_down;
  logic [7:0]              pen_cmd, tick_count;
  logic [2:0]              dir;
  logic                    z_pending, done_flag;

  logic                    div_start, div_done;
  logic [PositionBits-1:0] div_q, div_a;
  logic [CfgDataBits-1:0]  div_d;

  ccss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // digit accumulation, saturating
  function automatic logic [PositionBits-1:0] acc_digit(
    input logic [PositionBits-1:0] acc, input logic [7:0] b);
    logic [PositionBits+3:0] v;
    v = {4'd0, acc} * (PositionBits+4)'(10) + (PositionBits+4)'(b - ChZero);
    return (v > (PositionBits+4)'(MicronMax)) ? MicronMax : v[PositionBits-1:0];
  endfunction

  logic is_digit;
  assign is_digit = head.rx_byte >= ChZero && head.rx_byte <= ChNine;
  assign take     = avail && seq == S_RUN && !res_valid;
  assign res_valid = seq == S_OUT;

  // motion-start helpers operate on the registered state
  logic [7:0] half;
  logic [7:0] tick_inc;
  always_comb begin
    if (phase == PH_ZH || phase == PH_ZL) half = dir[2] ? z_down_half : z_up_half;
    else half = xy_half;
    tick_inc = tick_count + 8'd1;
  end

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (rst) begin
      seq        <= S_RUN;
      phase      <= PH_IDLE;
      byte_index <= '0;
      x_tm       <= '0;
      y_tm       <= '0;
      frozen     <= 1'b0;
      pen_cmd    <= '0;
      x_pos      <= '0;
      y_pos      <= '0;
      pen_down   <= 1'b1;
      steps_left <= '0;
      tick_count <= '0;
      x_ts       <= '0;
      y_ts       <= '0;
      dir        <= 3'b100;
      z_pending  <= 1'b0;
      done_flag  <= 1'b0;
      div_a      <= '0;
      div_d      <= '0;
    end else begin
      unique case (seq)
        S_RUN: begin
          if (take) begin
            done_flag <= 1'b0;
            seq       <= S_OUT;
            if (head.kind) begin
              if (phase != PH_IDLE) begin
                if (tick_inc < half) begin
                  tick_count <= tick_inc;
                end else begin
                  tick_count <= '0;
                  priority if (phase == PH_ZH || phase == PH_XH || phase == PH_YH) begin
                    phase <= phase_t'(phase + 3'd1);
                  end else begin
                    if (phase == PH_XL)
                      x_pos <= dir[0] ? x_pos + 1'b1 : x_pos - 1'b1;
                    if (phase == PH_YL)
                      y_pos <= dir[1] ? y_pos + 1'b1 : y_pos - 1'b1;
                    steps_left <= steps_left - 1'b1;
                    if (steps_left != PositionBits'(1)) begin
                      phase <= phase_t'(phase - 3'd1);
                    end else if (phase == PH_ZL) begin
                      // begin xy
                      if (!(x_pos == x_ts || y_pos == y_ts || pen_cmd == ChUp)) begin
                        phase <= PH_IDLE; done_flag <= 1'b1;
                      end else if (x_pos != x_ts) begin
                        dir[0] <= x_pos < x_ts;
                        steps_left <= (x_pos < x_ts) ? x_ts - x_pos : x_pos - x_ts;
                        phase <= PH_XH;
                      end else if (y_pos != y_ts) begin
                        dir[1] <= y_pos < y_ts;
                        steps_left <= (y_pos < y_ts) ? y_ts - y_pos : y_pos - y_ts;
                        phase <= PH_YH;
                      end else begin
                        phase <= PH_IDLE; done_flag <= 1'b1;
                      end
                    end else if (phase == PH_XL) begin
                      // x done, y next if it is off target
                      if (y_pos != y_ts) begin
                        dir[1] <= y_pos < y_ts;
                        steps_left <= (y_pos < y_ts) ? y_ts - y_pos : y_pos - y_ts;
                        phase <= PH_YH;
                      end else begin
                        phase <= PH_IDLE; done_flag <= 1'b1;
                      end
                    end else begin
                      phase <= PH_IDLE; done_flag <= 1'b1;
                    end
                  end
                end
              end
            end else if (phase == PH_IDLE) begin
              if (byte_index == '0) begin
                if (head.rx_byte == ChStart) begin
                  byte_index <= IdxBits'(1);
                  x_tm       <= '0;
                  frozen     <= 1'b0;
                end
              end else if (byte_index == PenIdx) begin
                byte_index <= '0;
                pen_cmd    <= head.rx_byte;
                z_pending  <= 1'b0;
                if (head.rx_byte == ChDown && !pen_down) begin
                  pen_down <= 1'b1; dir[2] <= 1'b1; z_pending <= 1'b1;
                end else if (head.rx_byte == ChUp && pen_down) begin
                  pen_down <= 1'b0; dir[2] <= 1'b0; z_pending <= 1'b1;
                end
                div_a     <= x_tm;
                div_d     <= x_mps;
                div_start <= 1'b1;
                seq       <= S_DIVX;
              end else begin
                if (byte_index <= LastX) begin
                  if (frozen || !is_digit) frozen <= 1'b1;
                  else x_tm <= acc_digit(x_tm, head.rx_byte);
                end else if (byte_index == YStart) begin
                  y_tm   <= '0;
                  frozen <= 1'b0;
                end else if (byte_index <= LastY) begin
                  if (frozen || !is_digit) frozen <= 1'b1;
                  else y_tm <= acc_digit(y_tm, head.rx_byte);
                end
                byte_index <= byte_index + 1'b1;
              end
            end
          end
        end
        S_DIVX: begin
          if (div_done) begin
            x_ts      <= div_q;
            div_a     <= y_tm;
            div_d     <= y_mps;
            div_start <= 1'b1;
            seq       <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            y_ts       <= div_q;
            seq        <= S_OUT;
            tick_count <= '0;
            if (z_pending && z_count != '0) begin
              steps_left <= PositionBits'(z_count);
              phase      <= PH_ZH;
            end else if (!(x_pos == x_ts || y_pos == div_q || pen_cmd == ChUp)) begin
              phase <= PH_IDLE; done_flag <= 1'b1;
            end else if (x_pos != x_ts) begin
              dir[0] <= x_pos < x_ts;
              steps_left <= (x_pos < x_ts) ? x_ts - x_pos : x_pos - x_ts;
              phase <= PH_XH;
            end else if (y_pos != div_q) begin
              dir[1] <= y_pos < div_q;
              steps_left <= (y_pos < div_q) ? div_q - y_pos : y_pos - div_q;
              phase <= PH_YH;
            end else begin
              phase <= PH_IDLE; done_flag <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (res_taken) seq <= S_RUN;
        end
        default: seq <= S_RUN;
      endcase
    end
  end

  always_comb begin
    res.x_step   = phase == PH_XH;
    res.x_dir    = dir[0];
    res.y_step   = phase == PH_YH;
    res.y_dir    = dir[1];
    res.z_step   = phase == PH_ZH;
    res.z_dir    = dir[2];
    res.ack      = done_flag;
    res.busy_res = byte_index != '0 || phase != PH_IDLE;
  end

endmodule
`default_nettype wire

>>> hdl/cnc_command_stepper_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnc_command_stepper_sequencer
// plotter command parser with pen, x and y step pulse sequencing
// ----------------------------------------------------------------------------
// the result is registered into the output state after the input transfer; for
// the pen byte the x and y divisions run one after the other before it appears
// the back end takes no new item until its result is popped; the two-entry
// input queue keeps accepting while a result waits to be popped
// reset: synchronous, clears the queue, pen down, registers to their defaults
module cnc_command_stepper_sequencer
  import ccss_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic                   kind,
  input  wire logic [7:0]             rx_byte,
  output logic                        empty,
  input  wire logic                   pop,
  output logic                        x_step,
  output logic                        x_dir,
  output logic                        y_step,
  output logic                        y_dir,
  output logic                        z_step,
  output logic                        z_dir,
  output logic                        ack,
  output logic                        busy_res,
  input  wire logic                   cfg_we,
  input  wire logic [CfgIdxBits-1:0]  cfg_index,
  input  wire logic [CfgDataBits-1:0] cfg_data
);

  // configuration registers
  logic [CfgDataBits-1:0] x_mps, y_mps;
  logic [7:0]             xy_half, z_down_half, z_up_half, z_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_mps       <= 10'd147;
      y_mps       <= 10'd227;
      xy_half     <= 8'd2;
      z_down_half <= 8'd5;
      z_up_half   <= 8'd2;
      z_count     <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegXMps:   x_mps       <= cfg_data;
        RegYMps:   y_mps       <= cfg_data;
        RegXyHalf: xy_half     <= cfg_data[7:0];
        RegZDown:  z_down_half <= cfg_data[7:0];
        RegZUp:    z_up_half   <= cfg_data[7:0];
        RegZCount: z_count     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // front: input queue
  logic    avail, take;
  item_t   head;

  ccss_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .kind    (kind),
    .rx_byte (rx_byte),
    .full    (full),
    .take    (take),
    .avail   (avail),
    .head    (head)
  );

  // back: parser and sequencer, holding its result until transferred
  logic    res_valid;
  result_t res;

  ccss_back u_back (
    .clk         (clk),
    .rst         (rst),
    .avail       (avail),
    .head        (head),
    .take        (take),
    .x_mps       (x_mps),
    .y_mps       (y_mps),
    .xy_half     (xy_half),
    .z_down_half (z_down_half),
    .z_up_half   (z_up_half),
    .z_count     (z_count),
    .res_valid   (res_valid),
    .res         (res),
    .res_taken   (pop)
  );

  assign empty    = !res_valid;
  assign x_step   = res.x_step;
  assign x_dir    = res.x_dir;
  assign y_step   = res.y_step;
  assign y_dir    = res.y_dir;
  assign z_step   = res.z_step;
  assign z_dir    = res.z_dir;
  assign ack      = res.ack;
  assign busy_res = res.busy_res;

endmodule
`default_nettype wire
